[rtl/affine_rect_bounding_box_unit_defines.svh]
// Assertion helpers for the top-level unit; sampled on i_clk, off while in reset.
`ifndef AFFINE_RECT_BOUNDING_BOX_UNIT_DEFINES_SVH
`define AFFINE_RECT_BOUNDING_BOX_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ABB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication.
`define ABB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

[rtl/abb_pkg.sv]
package abb_pkg;

    localparam int COORD_BITS   = 24;
    localparam int SIZE_BITS    = COORD_BITS - 1;
    localparam int CFG_IDX_BITS = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YX  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YY  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
        logic [SIZE_BITS-1:0]         in_width;
        logic [SIZE_BITS-1:0]         in_height;
    } t_abb_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [SIZE_BITS-1:0]         out_width;
        logic [SIZE_BITS-1:0]         out_height;
    } t_abb_out;

    // Coefficients and translation for one output axis
    typedef struct packed {
        logic signed [COORD_BITS-1:0] k_a;
        logic signed [COORD_BITS-1:0] k_b;
        logic signed [COORD_BITS-1:0] offset;
    } t_abb_axis_cfg;

endpackage

[rtl/abb_axis.sv]
// One output axis: products, per-term min/max, sums, floor shift and saturation.
// min over corners of a*xi + b*yj separates into min(a*xi) + min(b*yj); same for max.
module abb_axis #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  abb_pkg::t_abb_axis_cfg                   i_cfg,
    input  logic signed [abb_pkg::COORD_BITS:0]      i_a0,
    input  logic signed [abb_pkg::COORD_BITS:0]      i_a1,
    input  logic signed [abb_pkg::COORD_BITS:0]      i_b0,
    input  logic signed [abb_pkg::COORD_BITS:0]      i_b1,
    output logic signed [abb_pkg::COORD_BITS-1:0]    o_pos,
    output logic [abb_pkg::SIZE_BITS-1:0]            o_size
);
    import abb_pkg::*;

    localparam int PW = 2 * COORD_BITS + 1;   // product width
    localparam int SW = PW + 2;               // sum of two products and offset
    localparam int QW = SW - COEF_FRAC_BITS;  // after dropping the fraction
    localparam int DW = QW + 1;               // max - min

    // stage 1: products
    logic signed [PW-1:0] n_pa0, n_pa1, n_pb0, n_pb1;
    logic signed [PW-1:0] r_pa0, r_pa1, r_pb0, r_pb1;

    assign n_pa0 = PW'(i_cfg.k_a) * PW'(i_a0);
    assign n_pa1 = PW'(i_cfg.k_a) * PW'(i_a1);
    assign n_pb0 = PW'(i_cfg.k_b) * PW'(i_b0);
    assign n_pb1 = PW'(i_cfg.k_b) * PW'(i_b1);

    always_ff @(posedge i_clk) begin
        r_pa0 <= n_pa0;
        r_pa1 <= n_pa1;
        r_pb0 <= n_pb0;
        r_pb1 <= n_pb1;
    end

    // stage 2: min and max of each term
    logic signed [PW-1:0] n_lo_a, n_hi_a, n_lo_b, n_hi_b;
    logic signed [PW-1:0] r_lo_a, r_hi_a, r_lo_b, r_hi_b;

    assign n_lo_a = (r_pa0 < r_pa1) ? r_pa0 : r_pa1;
    assign n_hi_a = (r_pa0 < r_pa1) ? r_pa1 : r_pa0;
    assign n_lo_b = (r_pb0 < r_pb1) ? r_pb0 : r_pb1;
    assign n_hi_b = (r_pb0 < r_pb1) ? r_pb1 : r_pb0;

    always_ff @(posedge i_clk) begin
        r_lo_a <= n_lo_a;
        r_hi_a <= n_hi_a;
        r_lo_b <= n_lo_b;
        r_hi_b <= n_hi_b;
    end

    // stage 3: exact sums with the translation scaled to coefficient units
    logic signed [SW-1:0] off_ext;
    logic signed [SW-1:0] n_lo_sum, n_hi_sum;
    logic signed [SW-1:0] r_lo_sum, r_hi_sum;

    assign off_ext  = SW'(i_cfg.offset) <<< COEF_FRAC_BITS;
    assign n_lo_sum = SW'(r_lo_a) + SW'(r_lo_b) + off_ext;
    assign n_hi_sum = SW'(r_hi_a) + SW'(r_hi_b) + off_ext;

    always_ff @(posedge i_clk) begin
        r_lo_sum <= n_lo_sum;
        r_hi_sum <= n_hi_sum;
    end

    // stage 4: floor shift, span, saturation
    logic signed [QW-1:0]         q_lo, q_hi;
    logic signed [DW-1:0]         diff;
    logic                         lo_fits, size_fits;
    logic signed [COORD_BITS-1:0] n_pos, r_pos;
    logic [SIZE_BITS-1:0]         n_size, r_size;

    assign q_lo = QW'(r_lo_sum >>> COEF_FRAC_BITS);
    assign q_hi = QW'(r_hi_sum >>> COEF_FRAC_BITS);
    assign diff = DW'(q_hi) - DW'(q_lo);

    // in range when all bits above the coordinate sign agree with it
    assign lo_fits   = (q_lo[QW-1:COORD_BITS-1] == '0) || (q_lo[QW-1:COORD_BITS-1] == '1);
    assign size_fits = (diff[DW-1:SIZE_BITS] == '0);

    always_comb begin
        if (lo_fits) begin
            n_pos = q_lo[COORD_BITS-1:0];
        end else if (q_lo[QW-1]) begin
            n_pos = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            n_pos = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        n_size = size_fits ? diff[SIZE_BITS-1:0] : {SIZE_BITS{1'b1}};
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_size <= n_size;
    end

    assign o_pos  = r_pos;
    assign o_size = r_size;

endmodule

[rtl/affine_rect_bounding_box_unit.sv]
// Channel  | Signals                        | Transfer
// ---------+--------------------------------+-----------------------------------
// item in  | start, busy, i_item            | edge with start high, busy low
// result   | o_done, o_result               | the edge ending the o_done cycle
// config   | i_cfg_we, i_cfg_idx, i_cfg_data| edge with i_cfg_we high
//
// One item per cycle while busy is low; an item passes the input, product, min/max, sum
// and saturation registers in turn, and o_done rises together with its result.
// busy is high only during reset; the pipeline never holds an item back.
// Reset clears the valid chain and loads the identity transform.
// Results cannot be stalled: they are shown for one cycle, fixed latency.
`include "affine_rect_bounding_box_unit_defines.svh"

module affine_rect_bounding_box_unit #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  abb_pkg::t_abb_in                     i_item,
    output logic                                 o_done,
    output abb_pkg::t_abb_out                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [abb_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [abb_pkg::COORD_BITS-1:0]       i_cfg_data
);
    import abb_pkg::*;

    localparam int LAT = 5;
    localparam logic [COORD_BITS-1:0] COEF_ONE = COORD_BITS'(1) << COEF_FRAC_BITS;

    logic accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // configuration registers
    logic signed [COORD_BITS-1:0] r_coef_xx, r_coef_xy, r_offset_x;
    logic signed [COORD_BITS-1:0] r_coef_yx, r_coef_yy, r_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= COEF_ONE;
            r_coef_xy  <= '0;
            r_offset_x <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= COEF_ONE;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF_XX:  r_coef_xx  <= i_cfg_data;
                REG_COEF_XY:  r_coef_xy  <= i_cfg_data;
                REG_OFFSET_X: r_offset_x <= i_cfg_data;
                REG_COEF_YX:  r_coef_yx  <= i_cfg_data;
                REG_COEF_YY:  r_coef_yy  <= i_cfg_data;
                REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: near and far corners, both kept one bit wider than a coordinate
    logic signed [COORD_BITS:0] n_x0, n_y0, n_x1, n_y1;
    logic signed [COORD_BITS:0] r_x0, r_y0, r_x1, r_y1;

    assign n_x0 = {i_item.in_x[COORD_BITS-1], i_item.in_x};
    assign n_y0 = {i_item.in_y[COORD_BITS-1], i_item.in_y};
    assign n_x1 = n_x0 + {2'b00, i_item.in_width};
    assign n_y1 = n_y0 + {2'b00, i_item.in_height};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_x1 <= n_x1;
            r_y1 <= n_y1;
        end
    end

    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    t_abb_axis_cfg cfg_x, cfg_y;

    assign cfg_x = '{k_a: r_coef_xx, k_b: r_coef_xy, offset: r_offset_x};
    assign cfg_y = '{k_a: r_coef_yx, k_b: r_coef_yy, offset: r_offset_y};

    logic signed [COORD_BITS-1:0] pos_x, pos_y;
    logic [SIZE_BITS-1:0]         size_x, size_y;

    abb_axis #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_axis_x (
        .i_clk  (i_clk),
        .i_cfg  (cfg_x),
        .i_a0   (r_x0),
        .i_a1   (r_x1),
        .i_b0   (r_y0),
        .i_b1   (r_y1),
        .o_pos  (pos_x),
        .o_size (size_x)
    );

    abb_axis #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_axis_y (
        .i_clk  (i_clk),
        .i_cfg  (cfg_y),
        .i_a0   (r_x0),
        .i_a1   (r_x1),
        .i_b0   (r_y0),
        .i_b1   (r_y1),
        .o_pos  (pos_y),
        .o_size (size_y)
    );

    assign o_result = '{out_x: pos_x, out_y: pos_y, out_width: size_x, out_height: size_y};
    assign o_done   = r_vld[LAT-1];

    // every transfer in comes out after the fixed latency, and nothing else does
    `ABB_ASSERT_NXT(a_done_follows, accept, ##(LAT-1) o_done, "missing result")
    `ABB_ASSERT_IMP(a_done_has_item, o_done, $past(accept, LAT), "result without item")
    // a point maps to a point whatever the coefficients
    `ABB_ASSERT_IMP(a_point_width, o_done && $past(accept && i_item.in_width == '0 && i_item.in_height == '0, LAT),
        o_result.out_width == '0, "nonzero width for point item")
    `ABB_ASSERT_IMP(a_point_height, o_done && $past(accept && i_item.in_width == '0 && i_item.in_height == '0, LAT),
        o_result.out_height == '0, "nonzero height for point item")

endmodule
